// ===== hw/rtl/i2crm_pkg.sv =====
// Types, constants and phase codes shared by the I2C register master.
package i2crm_pkg;

    localparam int MAX_BYTES   = 16;
    localparam int BUF_AW      = $clog2(MAX_BYTES);
    localparam int COUNT_W     = 5;
    localparam int DEV_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int BITCNT_W    = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_LOAD  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_START0 = 5'd1,
        PH_START1 = 5'd2,
        PH_START2 = 5'd3,
        PH_START3 = 5'd4,
        PH_WBIT0  = 5'd5,
        PH_WBIT1  = 5'd6,
        PH_WBIT2  = 5'd7,
        PH_WACK0  = 5'd8,
        PH_WACK1  = 5'd9,
        PH_WACK2  = 5'd10,
        PH_WACK3  = 5'd11,
        PH_RBIT0  = 5'd12,
        PH_RBIT1  = 5'd13,
        PH_RBIT2  = 5'd14,
        PH_RACK0  = 5'd15,
        PH_RACK1  = 5'd16,
        PH_RACK2  = 5'd17,
        PH_STOP0  = 5'd18,
        PH_STOP1  = 5'd19,
        PH_STOP2  = 5'd20
    } phase_t;

    typedef enum logic [1:0] {
        ST_ADDR  = 2'd0,
        ST_REG   = 2'd1,
        ST_DATA  = 2'd2,
        ST_RADDR = 2'd3
    } stage_t;

    typedef struct packed {
        cmd_t                command;
        logic [DEV_W-1:0]    device_address;
        logic [BYTE_W-1:0]   register_address;
        logic [COUNT_W-1:0]  byte_count;
        logic [BYTE_W-1:0]   write_byte;
        logic                sda_in;
    } item_t;

    typedef struct packed {
        logic                scl_out;
        logic                sda_out;
        logic                sda_drive;
        logic [BYTE_W-1:0]   read_data;
        logic                read_valid;
        logic                last_byte;
        logic                done_res;
        logic                fault;
        logic                busy_res;
    } result_t;

endpackage

// ===== hw/rtl/i2crm_core.sv =====
// Transfer sequencer: one pin phase per tick request, write buffer and transfer state.
module i2crm_core
    import i2crm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    output result_t result
);

    phase_t               phase_reg, phase_next;
    stage_t               stage_reg, stage_next;
    logic [BITCNT_W-1:0]  bit_reg, bit_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [COUNT_W-1:0]   index_reg, index_next;
    logic [DEV_W-1:0]     dev_reg, dev_next;
    logic [BYTE_W-1:0]    regaddr_reg, regaddr_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 rd_reg, rd_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 drv_reg, drv_next;
    logic                 nack_reg, nack_next;
    logic                 buf_we;
    logic [BYTE_W-1:0]    wbuf [MAX_BYTES];
    logic [BYTE_W-1:0]    wbuf_rd_reg;

    logic [BYTE_W-1:0]    rdata;
    logic                 rvalid, rlast, done, flt;
    logic                 final_rx;
    logic                 more_data;
    logic [COUNT_W-1:0]   cnt_sat;
    logic [BITCNT_W-1:0]  bit_inc;

    assign final_rx  = ({1'b0, index_reg} + (COUNT_W+1)'(1)) >= {1'b0, count_reg};
    assign more_data = (index_reg < count_reg) && (index_reg < COUNT_W'(MAX_BYTES));
    assign bit_inc   = bit_reg + BITCNT_W'(1);

    always_comb
    begin
        cnt_sat = item.byte_count;
        if (cnt_sat > COUNT_W'(MAX_BYTES))
        begin
            cnt_sat = COUNT_W'(MAX_BYTES);
        end
        if ((item.command == CMD_READ) && (cnt_sat == '0))
        begin
            cnt_sat = COUNT_W'(1);
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        stage_next   = stage_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        index_next   = index_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        count_next   = count_reg;
        rd_next      = rd_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        drv_next     = drv_reg;
        nack_next    = nack_reg;
        buf_we       = 1'b0;
        rdata        = '0;
        rvalid       = 1'b0;
        rlast        = 1'b0;
        done         = 1'b0;
        flt          = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if ((item.command == CMD_WRITE) || (item.command == CMD_READ))
            begin
                dev_next     = item.device_address;
                regaddr_next = item.register_address;
                count_next   = cnt_sat;
                rd_next      = (item.command == CMD_READ);
                index_next   = '0;
                stage_next   = ST_ADDR;
                nack_next    = 1'b0;
                phase_next   = PH_START0;
            end
            else if (item.command == CMD_LOAD)
            begin
                if (index_reg < COUNT_W'(MAX_BYTES))
                begin
                    buf_we     = 1'b1;
                    index_next = index_reg + COUNT_W'(1);
                end
            end
        end
        else if (item.command == CMD_TICK)
        begin
            unique case (phase_reg)
                PH_START0:
                begin
                    drv_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_START1;
                end
                PH_START1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_START2;
                end
                PH_START2:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_START3;
                end
                PH_START3:
                begin
                    scl_next   = 1'b0;
                    shift_next = {dev_reg, (stage_reg == ST_RADDR)};
                    bit_next   = '0;
                    phase_next = PH_WBIT0;
                end
                PH_WBIT0:
                begin
                    drv_next   = 1'b1;
                    sda_next   = shift_reg[BYTE_W-1];
                    shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                    phase_next = PH_WBIT1;
                end
                PH_WBIT1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WBIT2;
                end
                PH_WBIT2:
                begin
                    scl_next   = 1'b0;
                    bit_next   = bit_inc;
                    phase_next = (bit_inc >= BITCNT_W'(BYTE_W)) ? PH_WACK0 : PH_WBIT0;
                end
                PH_WACK0:
                begin
                    drv_next   = 1'b0;
                    sda_next   = 1'b1;
                    phase_next = PH_WACK1;
                end
                PH_WACK1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WACK2;
                end
                PH_WACK2:
                begin
                    nack_next  = item.sda_in;
                    phase_next = PH_WACK3;
                end
                PH_WACK3:
                begin
                    scl_next = 1'b0;
                    if (nack_reg)
                    begin
                        phase_next = PH_STOP0;
                    end
                    else if (stage_reg == ST_ADDR)
                    begin
                        stage_next = ST_REG;
                        shift_next = regaddr_reg;
                        bit_next   = '0;
                        phase_next = PH_WBIT0;
                    end
                    else if ((stage_reg == ST_REG) && rd_reg)
                    begin
                        stage_next = ST_RADDR;
                        phase_next = PH_START0;
                    end
                    else if ((stage_reg == ST_REG) || (stage_reg == ST_DATA))
                    begin
                        stage_next = ST_DATA;
                        if (more_data)
                        begin
                            shift_next = wbuf_rd_reg;
                            index_next = index_reg + COUNT_W'(1);
                            bit_next   = '0;
                            phase_next = PH_WBIT0;
                        end
                        else
                        begin
                            phase_next = PH_STOP0;
                        end
                    end
                    else
                    begin
                        index_next = '0;
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_RBIT0;
                    end
                end
                PH_RBIT0:
                begin
                    drv_next   = 1'b0;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_RBIT1;
                end
                PH_RBIT1:
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], item.sda_in};
                    if (bit_reg == BITCNT_W'(BYTE_W-1))
                    begin
                        rvalid = 1'b1;
                        rdata  = {shift_reg[BYTE_W-2:0], item.sda_in};
                        rlast  = final_rx;
                    end
                    phase_next = PH_RBIT2;
                end
                PH_RBIT2:
                begin
                    scl_next   = 1'b0;
                    bit_next   = bit_inc;
                    phase_next = (bit_inc >= BITCNT_W'(BYTE_W)) ? PH_RACK0 : PH_RBIT0;
                end
                PH_RACK0:
                begin
                    drv_next   = 1'b1;
                    sda_next   = final_rx;
                    phase_next = PH_RACK1;
                end
                PH_RACK1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RACK2;
                end
                PH_RACK2:
                begin
                    scl_next   = 1'b0;
                    index_next = index_reg + COUNT_W'(1);
                    if (final_rx)
                    begin
                        phase_next = PH_STOP0;
                    end
                    else
                    begin
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_RBIT0;
                    end
                end
                PH_STOP0:
                begin
                    drv_next   = 1'b1;
                    sda_next   = 1'b0;
                    phase_next = PH_STOP1;
                end
                PH_STOP1:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_STOP2;
                end
                PH_STOP2:
                begin
                    drv_next   = 1'b1;
                    sda_next   = 1'b1;
                    done       = 1'b1;
                    flt        = nack_reg;
                    nack_next  = 1'b0;
                    index_next = '0;
                    bit_next   = '0;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        result.scl_out    = scl_next;
        result.sda_out    = sda_next;
        result.sda_drive  = drv_next;
        result.read_data  = rdata;
        result.read_valid = rvalid;
        result.last_byte  = rlast;
        result.done_res   = done;
        result.fault      = flt;
        result.busy_res   = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            stage_reg   <= ST_ADDR;
            bit_reg     <= '0;
            shift_reg   <= '0;
            index_reg   <= '0;
            dev_reg     <= '0;
            regaddr_reg <= '0;
            count_reg   <= '0;
            rd_reg      <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            drv_reg     <= 1'b1;
            nack_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            stage_reg   <= stage_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            index_reg   <= index_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            count_reg   <= count_next;
            rd_reg      <= rd_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            drv_reg     <= drv_next;
            nack_reg    <= nack_next;
        end
    end

    // prefetch the entry at the next byte position
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            if (buf_we)
            begin
                wbuf[index_reg[BUF_AW-1:0]] <= item.write_byte;
            end
            wbuf_rd_reg <= wbuf[index_next[BUF_AW-1:0]];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (count_reg <= COUNT_W'(MAX_BYTES)))
        else $error("held byte count above buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RBIT1 || phase_reg == PH_RBIT2) |-> (!drv_reg && stage_reg == ST_RADDR))
        else $error("read bit phase with SDA driven or outside read stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && phase_reg == PH_STOP2 && item.command == CMD_TICK)
            |=> (phase_reg == PH_IDLE && index_reg == '0 && !nack_reg))
        else $error("stop did not return sequencer to idle");

endmodule

// ===== hw/rtl/i2c_register_master.sv =====
// Top level of the I2C register master: stream ports, input and result registers.
//
// Usage: every request on the s_axis side is one command. tuser carries the
// command (tick one pin phase, begin write, begin read, load write byte);
// tdata carries device address, register address, byte count, the byte to
// load and the sampled SDA level. Load bytes first, then begin a write; a
// read needs only the begin. Then send one tick per pin phase, sampling SDA
// into each tick. Every request produces exactly one result on m_axis with
// the pin levels to apply, a received byte (tuser high, tlast on the final
// byte), done/fault at the stop and the busy flag.
// A request is held in the input register and then in the result register
// before m_axis_tvalid rises with its result.
// Throughput: one request per cycle while m_axis_tready is high; the sequencer
// advances one phase per tick request between the input and result registers.
// Reset: SCL high, SDA high and driven, sequencer idle, both registers empty.
// Stall: while m_axis_tready is low the result holds, one more request is
// taken into the input register, then s_axis_tready drops.
module i2c_register_master
    import i2crm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [6:0] device_address, [14:7] register_address, [19:15] byte_count,
    // [27:20] write_byte, [28] sda_in, [31:29] zero
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] command
    input  logic [1:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] sda_drive, [10:3] read_data,
    // [11] done_res, [12] fault, [13] busy_res, [15:14] zero
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] read_valid
    output logic                    m_axis_tuser,
    // last_byte
    output logic                    m_axis_tlast
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    item_t   in_item;
    logic    out_valid_reg;
    result_t out_reg;
    result_t core_result;
    logic    advance;

    assign in_item.command          = cmd_t'(s_axis_tuser);
    assign in_item.device_address   = s_axis_tdata[6:0];
    assign in_item.register_address = s_axis_tdata[14:7];
    assign in_item.byte_count       = s_axis_tdata[19:15];
    assign in_item.write_byte       = s_axis_tdata[27:20];
    assign in_item.sda_in           = s_axis_tdata[28];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    i2crm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.busy_res, out_reg.fault, out_reg.done_res,
                            out_reg.read_data, out_reg.sda_drive, out_reg.sda_out,
                            out_reg.scl_out};
    assign m_axis_tuser  = out_reg.read_valid;
    assign m_axis_tlast  = out_reg.last_byte;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.fault) |-> out_reg.done_res)
        else $error("fault reported without stop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> (!out_reg.busy_res && out_reg.sda_drive))
        else $error("stop result still busy or SDA released");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.read_valid)
            |-> (out_reg.busy_res && !out_reg.sda_drive && out_reg.scl_out))
        else $error("received byte outside a high SCL read phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last_byte) |-> out_reg.read_valid)
        else $error("last byte flag without received byte");

endmodule

// ===== sim/i2crm_bus_checker.sv =====
`timescale 1ns / 1ps
// Bus-phase predictor and result checker for the I2C register master.
module i2crm_bus_checker
    import i2crm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]             s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tuser,
    input  logic                   m_axis_tlast,
    output int                     fail_count,
    output int                     outstanding
);

    phase_t              phase;
    stage_t              stage;
    logic [BITCNT_W-1:0] bit_count;
    logic [BYTE_W-1:0]   shift_reg;
    logic [COUNT_W-1:0]  byte_pos;
    logic [BYTE_W-1:0]   tx_buffer [MAX_BYTES];
    logic [DEV_W-1:0]    req_dev;
    logic [BYTE_W-1:0]   req_reg;
    logic [COUNT_W-1:0]  req_len;
    logic                req_is_read;
    logic                scl_lvl;
    logic                sda_lvl;
    logic                sda_oe;
    logic                nack_latched;

    result_t pin_forecast [$];
    item_t   taken;
    result_t want;
    result_t seen;
    result_t next_pins;
    int      mismatches = 0;

    assign fail_count = mismatches;

    function automatic void compare_field(input string field, input logic [7:0] exp_val,
                                          input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0h, got %0h", field, exp_val, act_val);
            mismatches++;
        end
    endfunction

    task automatic shift_out_byte(input logic [BYTE_W-1:0] value);
        shift_reg = value;
        bit_count = '0;
        phase = PH_WBIT0;
    endtask

    task automatic next_data_or_stop();
        if (byte_pos < req_len && byte_pos < MAX_BYTES)
        begin
            shift_out_byte(tx_buffer[byte_pos[BUF_AW-1:0]]);
            byte_pos++;
        end
        else
            phase = PH_STOP0;
    endtask

    task automatic advance_i2c_phase(input item_t it, output result_t r);
        logic [COUNT_W-1:0] len;
        r = '0;
        if (phase == PH_IDLE)
        begin
            if (it.command == CMD_WRITE || it.command == CMD_READ)
            begin
                len = (it.byte_count > MAX_BYTES) ? COUNT_W'(MAX_BYTES) : it.byte_count;
                if (it.command == CMD_READ && len == 0)
                    len = COUNT_W'(1);
                req_dev = it.device_address;
                req_reg = it.register_address;
                req_len = len;
                req_is_read = (it.command == CMD_READ);
                byte_pos = '0;
                stage = ST_ADDR;
                nack_latched = 1'b0;
                phase = PH_START0;
            end
            else if (it.command == CMD_LOAD && byte_pos < MAX_BYTES)
            begin
                tx_buffer[byte_pos[BUF_AW-1:0]] = it.write_byte;
                byte_pos++;
            end
        end
        else if (it.command == CMD_TICK)
        begin
            case (phase)
                PH_START0:
                begin
                    sda_oe = 1'b1;
                    sda_lvl = 1'b1;
                    phase = PH_START1;
                end
                PH_START1:
                begin
                    scl_lvl = 1'b1;
                    phase = PH_START2;
                end
                PH_START2:
                begin
                    sda_lvl = 1'b0;
                    phase = PH_START3;
                end
                PH_START3:
                begin
                    scl_lvl = 1'b0;
                    shift_out_byte({req_dev, stage == ST_RADDR});
                end
                PH_WBIT0:
                begin
                    sda_oe = 1'b1;
                    sda_lvl = shift_reg[7];
                    shift_reg = {shift_reg[6:0], 1'b0};
                    phase = PH_WBIT1;
                end
                PH_WBIT1:
                begin
                    scl_lvl = 1'b1;
                    phase = PH_WBIT2;
                end
                PH_WBIT2:
                begin
                    scl_lvl = 1'b0;
                    bit_count++;
                    phase = (bit_count >= 8) ? PH_WACK0 : PH_WBIT0;
                end
                PH_WACK0:
                begin
                    sda_oe = 1'b0;
                    sda_lvl = 1'b1;
                    phase = PH_WACK1;
                end
                PH_WACK1:
                begin
                    scl_lvl = 1'b1;
                    phase = PH_WACK2;
                end
                PH_WACK2:
                begin
                    nack_latched = it.sda_in;
                    phase = PH_WACK3;
                end
                PH_WACK3:
                begin
                    scl_lvl = 1'b0;
                    if (nack_latched)
                        phase = PH_STOP0;
                    else
                    begin
                        case (stage)
                            ST_ADDR:
                            begin
                                stage = ST_REG;
                                shift_out_byte(req_reg);
                            end
                            ST_REG:
                            begin
                                if (req_is_read)
                                begin
                                    stage = ST_RADDR;
                                    phase = PH_START0;
                                end
                                else
                                begin
                                    stage = ST_DATA;
                                    next_data_or_stop();
                                end
                            end
                            ST_DATA:
                                next_data_or_stop();
                            default:
                            begin
                                byte_pos = '0;
                                bit_count = '0;
                                shift_reg = '0;
                                phase = PH_RBIT0;
                            end
                        endcase
                    end
                end
                PH_RBIT0:
                begin
                    sda_oe = 1'b0;
                    sda_lvl = 1'b1;
                    scl_lvl = 1'b1;
                    phase = PH_RBIT1;
                end
                PH_RBIT1:
                begin
                    shift_reg = {shift_reg[6:0], it.sda_in};
                    if (bit_count == 7)
                    begin
                        r.read_valid = 1'b1;
                        r.read_data = shift_reg;
                        r.last_byte = (byte_pos + 1 >= req_len);
                    end
                    phase = PH_RBIT2;
                end
                PH_RBIT2:
                begin
                    scl_lvl = 1'b0;
                    bit_count++;
                    phase = (bit_count >= 8) ? PH_RACK0 : PH_RBIT0;
                end
                PH_RACK0:
                begin
                    sda_oe = 1'b1;
                    sda_lvl = (byte_pos + 1 >= req_len);
                    phase = PH_RACK1;
                end
                PH_RACK1:
                begin
                    scl_lvl = 1'b1;
                    phase = PH_RACK2;
                end
                PH_RACK2:
                begin
                    scl_lvl = 1'b0;
                    byte_pos++;
                    if (byte_pos >= req_len)
                        phase = PH_STOP0;
                    else
                    begin
                        bit_count = '0;
                        shift_reg = '0;
                        phase = PH_RBIT0;
                    end
                end
                PH_STOP0:
                begin
                    sda_oe = 1'b1;
                    sda_lvl = 1'b0;
                    phase = PH_STOP1;
                end
                PH_STOP1:
                begin
                    scl_lvl = 1'b1;
                    phase = PH_STOP2;
                end
                default:
                begin
                    sda_oe = 1'b1;
                    sda_lvl = 1'b1;
                    r.done_res = 1'b1;
                    r.fault = nack_latched;
                    nack_latched = 1'b0;
                    byte_pos = '0;
                    bit_count = '0;
                    phase = PH_IDLE;
                end
            endcase
        end
        r.scl_out = scl_lvl;
        r.sda_out = sda_lvl;
        r.sda_drive = sda_oe;
        r.busy_res = (phase != PH_IDLE);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = PH_IDLE;
            stage = ST_ADDR;
            bit_count = '0;
            shift_reg = '0;
            byte_pos = '0;
            for (int i = 0; i < MAX_BYTES; i++)
                tx_buffer[i] = '0;
            req_dev = '0;
            req_reg = '0;
            req_len = '0;
            req_is_read = 1'b0;
            scl_lvl = 1'b1;
            sda_lvl = 1'b1;
            sda_oe = 1'b1;
            nack_latched = 1'b0;
            pin_forecast.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.scl_out = m_axis_tdata[0];
                seen.sda_out = m_axis_tdata[1];
                seen.sda_drive = m_axis_tdata[2];
                seen.read_data = m_axis_tdata[10:3];
                seen.done_res = m_axis_tdata[11];
                seen.fault = m_axis_tdata[12];
                seen.busy_res = m_axis_tdata[13];
                seen.read_valid = m_axis_tuser;
                seen.last_byte = m_axis_tlast;
                if (pin_forecast.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pin_forecast.pop_front();
                    compare_field("scl_out", 8'(want.scl_out), 8'(seen.scl_out));
                    compare_field("sda_out", 8'(want.sda_out), 8'(seen.sda_out));
                    compare_field("sda_drive", 8'(want.sda_drive), 8'(seen.sda_drive));
                    compare_field("read_data", want.read_data, seen.read_data);
                    compare_field("read_valid", 8'(want.read_valid), 8'(seen.read_valid));
                    compare_field("last_byte", 8'(want.last_byte), 8'(seen.last_byte));
                    compare_field("done_res", 8'(want.done_res), 8'(seen.done_res));
                    compare_field("fault", 8'(want.fault), 8'(seen.fault));
                    compare_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.command = cmd_t'(s_axis_tuser);
                taken.device_address = s_axis_tdata[6:0];
                taken.register_address = s_axis_tdata[14:7];
                taken.byte_count = s_axis_tdata[19:15];
                taken.write_byte = s_axis_tdata[27:20];
                taken.sda_in = s_axis_tdata[28];
                advance_i2c_phase(taken, next_pins);
                pin_forecast.push_back(next_pins);
            end
        end
        outstanding <= pin_forecast.size();
    end

endmodule

// ===== sim/tb_i2c_register_master.sv =====
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the I2C register master regression.
module tb_i2c_register_master;
    import i2crm_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_REQUESTS  = 1100;
    localparam int START_TICKS      = 4;
    localparam int STOP_TICKS       = 3;
    localparam int WRITE_BYTE_TICKS = 28;
    localparam int ACK_SAMPLE_TICK  = 26;
    localparam int READ_BYTE_TICKS  = 27;
    localparam int HOLD_OFF_AT      = 250;
    localparam int HOLD_OFF_CYCLES  = 120;
    localparam int DRAIN_CYCLES     = 20;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;
    int                     fail_count;
    int                     outstanding;

    int         requests_sent;
    int         loaded;
    int         filled;
    int         tx_style;
    int         tx_burst;
    int         rx_style;
    int         rx_burst;
    int         rx_gap;
    int         results_taken;
    int         cycle_count;
    bit         pick_read;
    logic [4:0] pick_len;
    int         len_cap;

    i2c_register_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    i2crm_bus_checker bus_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_wait(input int style);
        case (style)
            0:       return 0;
            1:       return $urandom_range(0, 11);
            default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        endcase
    endfunction

    function automatic item_t random_item(input cmd_t c);
        item_t it;
        it.command = c;
        it.device_address = 7'($urandom);
        it.register_address = 8'($urandom);
        it.byte_count = 5'($urandom);
        it.write_byte = 8'($urandom);
        it.sda_in = 1'($urandom);
        return it;
    endfunction

    task automatic push_request(input item_t it, input bit counted);
        int gap;
        if (tx_burst == 0)
        begin
            tx_style = $urandom_range(0, 2);
            tx_burst = $urandom_range(8, 60);
        end
        tx_burst--;
        gap = pick_wait(tx_style);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.command;
        s_axis_tdata <= {3'b000, it.sda_in, it.write_byte, it.byte_count,
                         it.register_address, it.device_address};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (counted)
            requests_sent++;
    endtask

    // slip in a begin or load now and then; the block is busy and must drop it
    task automatic tick(input logic sda);
        item_t it;
        if ($urandom_range(0, 39) == 0)
            push_request(random_item(cmd_t'($urandom_range(1, 3))), 1'b0);
        it = random_item(CMD_TICK);
        it.sda_in = sda;
        push_request(it, 1'b1);
    endtask

    task automatic clock_out_byte(input bit nack);
        for (int i = 0; i < WRITE_BYTE_TICKS; i++)
            tick((i == ACK_SAMPLE_TICK) ? nack : 1'($urandom));
    endtask

    task automatic clock_in_byte();
        int fill;
        fill = $urandom_range(0, 7);
        for (int i = 0; i < READ_BYTE_TICKS; i++)
            tick((fill == 0) ? 1'b0 : (fill == 1) ? 1'b1 : 1'($urandom));
    endtask

    task automatic load_bytes(input int n);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            it = random_item(CMD_LOAD);
            case ($urandom_range(0, 7))
                0:       it.write_byte = 8'h00;
                1:       it.write_byte = 8'hFF;
                default: ;
            endcase
            push_request(it, 1'b1);
            if (loaded < MAX_BYTES)
            begin
                loaded++;
                if (loaded > filled)
                    filled = loaded;
            end
        end
    endtask

    task automatic run_transfer(input bit rd, input logic [6:0] dev, input logic [7:0] regb,
                                input logic [4:0] len, input int nack_at);
        item_t it;
        int    in_bytes;
        int    out_bytes;
        bit    nacked;
        in_bytes = (len > MAX_BYTES) ? MAX_BYTES : len;
        if (rd && in_bytes == 0)
            in_bytes = 1;
        out_bytes = rd ? 3 : 2 + in_bytes;
        it = random_item(rd ? CMD_READ : CMD_WRITE);
        it.device_address = dev;
        it.register_address = regb;
        it.byte_count = len;
        push_request(it, 1'b1);
        loaded = 0;
        nacked = 1'b0;
        repeat (START_TICKS) tick(1'($urandom));
        for (int b = 0; b < out_bytes && !nacked; b++)
        begin
            if (rd && b == 2)
                repeat (START_TICKS) tick(1'($urandom));
            clock_out_byte(b == nack_at);
            nacked = (b == nack_at);
        end
        if (rd && !nacked)
            repeat (in_bytes) clock_in_byte();
        repeat (STOP_TICKS) tick(1'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        requests_sent = 0;
        loaded = 0;
        filled = 0;
        tx_burst = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        push_request(random_item(CMD_TICK), 1'b0);
        load_bytes(MAX_BYTES + 1);
        run_transfer(1'b0, 7'h7F, 8'hFF, 5'd31, -1);
        run_transfer(1'b0, 7'h00, 8'h00, 5'd0, -1);
        run_transfer(1'b1, 7'h2A, 8'h81, 5'd0, -1);
        run_transfer(1'b1, 7'h7F, 8'h00, 5'd31, -1);
        load_bytes(2);
        run_transfer(1'b0, 7'h15, 8'h3C, 5'd2, 0);
        run_transfer(1'b1, 7'h40, 8'hC3, 5'd3, 2);
        load_bytes(3);
        run_transfer(1'b1, 7'h01, 8'h7E, 5'd16, 1);
        run_transfer(1'b0, 7'h6B, 8'h5A, 5'd16, 5);

        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 5) == 0)
                push_request(random_item(CMD_TICK), 1'b0);
            load_bytes(($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_BYTES + 2)
                                                   : $urandom_range(0, 3));
            pick_read = ($urandom_range(0, 9) < 4);
            if (pick_read)
                pick_len = ($urandom_range(0, 5) == 0) ? 5'($urandom)
                                                       : 5'($urandom_range(0, 3));
            else if (filled == MAX_BYTES && $urandom_range(0, 3) == 0)
                pick_len = 5'($urandom);
            else
            begin
                len_cap = ($urandom_range(0, 4) == 0) ? filled : ((filled < 3) ? filled : 3);
                pick_len = 5'($urandom_range(0, len_cap));
            end
            run_transfer(pick_read, 7'($urandom), 8'($urandom), pick_len,
                         ($urandom_range(0, 6) == 0) ? $urandom_range(0, 5) : -1);
        end

        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("i2c_register_master regression: pass");
        else
            $display("i2c_register_master regression: fail");
        $finish;
    end

    // hold the result side off once for a long stretch so the block backs up
    initial
    begin
        m_axis_tready = 1'b0;
        rx_burst = 0;
        results_taken = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_taken == HOLD_OFF_AT)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (rx_burst == 0)
                begin
                    rx_style = $urandom_range(0, 2);
                    rx_burst = $urandom_range(8, 60);
                end
                rx_burst--;
                rx_gap = pick_wait(rx_style);
                if (rx_gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (rx_gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            results_taken++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("i2c_register_master regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/i2crm_pkg.sv
hw/rtl/i2crm_core.sv
hw/rtl/i2c_register_master.sv
sim/i2crm_bus_checker.sv
sim/tb_i2c_register_master.sv
